### rtl/core/och_pkg.sv
// ----------------------------------------------------------------------------
// och_pkg
// Shared types and constants of the object contact histogram: field widths,
// action and status codes, configuration register indexes.
// ----------------------------------------------------------------------------
package och_pkg;

  // Field widths.
  localparam int ACT_W      = 3;
  localparam int VTX_W      = 12;
  localparam int OBJ_W      = 9;
  localparam int CNT_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int VCOUNT_W   = 13;

  // Object number that stands for "no object".
  localparam logic [OBJ_W-1:0] NO_OBJECT = 9'h1FF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COUNT  = 2'd2;

  // Input actions.
  typedef enum logic [ACT_W-1:0] {
    ACT_DYN_PAIR    = 3'd0,
    ACT_DYN_STATIC  = 3'd1,
    ACT_ANALYTIC    = 3'd2,
    ACT_LOAD_DYN    = 3'd3,
    ACT_LOAD_STATIC = 3'd4,
    ACT_READ        = 3'd5
  } action_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_VERTEX   = 2'd2,
    ST_OBJECT   = 2'd3
  } status_t;

endpackage

### rtl/core/och_map_ram.sv
// ----------------------------------------------------------------------------
// och_map_ram
// Vertex-to-object map memory: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module och_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [och_pkg::OBJ_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [och_pkg::OBJ_W-1:0] rdata
);
  import och_pkg::*;

  logic [OBJ_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/och_cnt_ram.sv
// ----------------------------------------------------------------------------
// och_cnt_ram
// Contact counter memory: single port, read before write, registered read
// data.
// ----------------------------------------------------------------------------
module och_cnt_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [och_pkg::CNT_W-1:0] wdata,
  output logic [och_pkg::CNT_W-1:0] rdata
);
  import och_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];

  // Single shared port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/object_contact_histogram.sv
// ----------------------------------------------------------------------------
// object_contact_histogram
// Per-object contact histogram with dynamic and static vertex-to-object maps.
//
// The input channel (in_valid / in_stall) carries one action per transfer:
// a contact record, a map load or a counter read. Every action produces
// exactly one result transfer on the output channel (out_valid / out_stall).
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// by the user only while the block is idle; the block does not enforce it.
// Loads, unused actions, rejected records and reads outside the counter
// range go from the input transfer straight to the final step; counter
// reads pass a read step first. A recorded contact passes up to two map
// lookups (one for analytic records) and up to two read-modify-write passes
// over the single-port counter memory, each a read step and a write step;
// a side whose counter is not charged skips its write step. The sequencer
// returns to idle before it takes the next transfer.
// After reset the sequencer clears the counter memory, one entry a cycle;
// in_stall stays high meanwhile. A result that the receiver stalls is held
// in the output register; the next action can be taken and worked on, and
// it waits in its final step until the register frees up.
// ----------------------------------------------------------------------------
module object_contact_histogram #(
  parameter int MAX_OBJECTS      = 256,
  parameter int DYNAMIC_VERTICES = 4096,
  parameter int STATIC_VERTICES  = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           cfg_we,
  input  logic [och_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [och_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [och_pkg::ACT_W-1:0]      action,
  input  logic [och_pkg::VTX_W-1:0]      first_vertex,
  input  logic [och_pkg::VTX_W-1:0]      second_vertex,
  input  logic [och_pkg::OBJ_W-1:0]      object_id,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [och_pkg::CNT_W-1:0]      count_value,
  output logic                           charged_first,
  output logic                           charged_second,
  output logic [och_pkg::STATUS_W-1:0]   status
);
  import och_pkg::*;

  localparam int CntAw = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int DynAw = (DYNAMIC_VERTICES > 1) ? $clog2(DYNAMIC_VERTICES) : 1;
  localparam int StaAw = (STATIC_VERTICES > 1) ? $clog2(STATIC_VERTICES) : 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAPA,
    S_MAPB,
    S_CHA,
    S_WRA,
    S_CHB,
    S_WRB,
    S_READ,
    S_DONE
  } state_t;

  state_t               state;
  logic [CntAw-1:0]     clr_idx;

  // Configuration registers.
  logic [OBJ_W-1:0]     object_count;
  logic [VCOUNT_W-1:0]  dyn_count;
  logic [VCOUNT_W-1:0]  sta_count;

  // Action under work.
  action_t              act;
  logic [VTX_W-1:0]     vtx_b;
  logic [OBJ_W-1:0]     obj_a;
  logic [OBJ_W-1:0]     obj_b;
  logic                 rec_first;
  logic                 rec_second;
  status_t              rec_status;
  logic [CNT_W-1:0]     rec_count;

  // Memory ports.
  logic                 dyn_we;
  logic [DynAw-1:0]     dyn_raddr;
  logic [OBJ_W-1:0]     dyn_rdata;
  logic                 sta_we;
  logic [OBJ_W-1:0]     sta_rdata;
  logic                 cnt_we;
  logic [CntAw-1:0]     cnt_addr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic [CNT_W-1:0]     cnt_rdata;

  // Decode of the offered action.
  action_t              in_act;
  logic                 accept;
  logic                 vtx_bad;
  logic                 dyn_load_ok;
  logic                 sta_load_ok;
  logic                 read_ok;
  logic                 out_free;

  // An object is counted when below both the register and the memory depth.
  function automatic logic obj_in_range(input logic [OBJ_W-1:0] obj,
                                        input logic [OBJ_W-1:0] limit);
    obj_in_range = (obj < limit) && (32'(obj) < MAX_OBJECTS);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_act   = action_t'(action);
  assign out_free = !out_valid || !out_stall;

  // Vertex range checks against the effective map counts.
  always_comb begin
    vtx_bad = !(({1'b0, first_vertex} < dyn_count) &&
                (32'(first_vertex) < DYNAMIC_VERTICES));
    if (in_act == ACT_DYN_PAIR) begin
      vtx_bad = vtx_bad ||
                !(({1'b0, second_vertex} < dyn_count) &&
                  (32'(second_vertex) < DYNAMIC_VERTICES));
    end else if (in_act == ACT_DYN_STATIC) begin
      vtx_bad = vtx_bad ||
                !(({1'b0, second_vertex} < sta_count) &&
                  (32'(second_vertex) < STATIC_VERTICES));
    end
  end

  assign dyn_load_ok = (32'(first_vertex) < DYNAMIC_VERTICES);
  assign sta_load_ok = (32'(first_vertex) < STATIC_VERTICES);
  assign read_ok     = (32'(object_id) < MAX_OBJECTS);

  // Map loads write straight from the input transfer.
  assign dyn_we    = accept && (in_act == ACT_LOAD_DYN) && dyn_load_ok;
  assign sta_we    = accept && (in_act == ACT_LOAD_STATIC) && sta_load_ok;
  assign dyn_raddr = (state == S_MAPA) ? DynAw'(vtx_b) : DynAw'(first_vertex);

  // Counter memory port: clear sweep, reads and write-backs of the increment.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_addr  = CntAw'(obj_a);
    cnt_wdata = cnt_rdata + 32'd1;
    unique case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_addr  = clr_idx;
        cnt_wdata = '0;
      end
      S_IDLE:  cnt_addr = CntAw'(object_id);
      S_CHA:   cnt_addr = CntAw'(obj_a);
      S_WRA: begin
        cnt_we   = 1'b1;
        cnt_addr = CntAw'(obj_a);
      end
      S_CHB:   cnt_addr = CntAw'(obj_b);
      S_WRB: begin
        cnt_we   = 1'b1;
        cnt_addr = CntAw'(obj_b);
      end
      default: cnt_addr = CntAw'(obj_a);
    endcase
  end

  och_map_ram #(.DEPTH(DYNAMIC_VERTICES)) u_dyn_map (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (DynAw'(first_vertex)),
    .wdata (object_id),
    .raddr (dyn_raddr),
    .rdata (dyn_rdata)
  );

  och_map_ram #(.DEPTH(STATIC_VERTICES)) u_sta_map (
    .clk   (clk),
    .we    (sta_we),
    .waddr (StaAw'(first_vertex)),
    .wdata (object_id),
    .raddr (StaAw'(vtx_b)),
    .rdata (sta_rdata)
  );

  och_cnt_ram #(.DEPTH(MAX_OBJECTS)) u_counters (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      object_count <= '0;
      dyn_count    <= '0;
      sta_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OBJECT_COUNT:  object_count <= cfg_data[OBJ_W-1:0];
        CFG_DYNAMIC_COUNT: dyn_count    <= cfg_data[VCOUNT_W-1:0];
        CFG_STATIC_COUNT:  sta_count    <= cfg_data[VCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // The final step loads the output register itself.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CntAw'(MAX_OBJECTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act        <= in_act;
            vtx_b      <= second_vertex;
            rec_first  <= 1'b0;
            rec_second <= 1'b0;
            rec_count  <= '0;
            case (in_act) inside
              ACT_DYN_PAIR, ACT_DYN_STATIC, ACT_ANALYTIC: begin
                if (object_count == '0) begin
                  rec_status <= ST_DISABLED;
                  state      <= S_DONE;
                end else if (vtx_bad) begin
                  rec_status <= ST_VERTEX;
                  state      <= S_DONE;
                end else begin
                  rec_status <= ST_OK;
                  state      <= S_MAPA;
                end
              end
              ACT_LOAD_DYN: begin
                rec_status <= dyn_load_ok ? ST_OK : ST_VERTEX;
                state      <= S_DONE;
              end
              ACT_LOAD_STATIC: begin
                rec_status <= sta_load_ok ? ST_OK : ST_VERTEX;
                state      <= S_DONE;
              end
              ACT_READ: begin
                if (read_ok) begin
                  rec_status <= ST_OK;
                  state      <= S_READ;
                end else begin
                  rec_status <= ST_OBJECT;
                  state      <= S_DONE;
                end
              end
              default: begin
                rec_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_MAPA: begin
          obj_a <= dyn_rdata;
          if (act == ACT_ANALYTIC) begin
            obj_b <= NO_OBJECT;
            state <= S_CHA;
          end else begin
            state <= S_MAPB;
          end
        end
        S_MAPB: begin
          obj_b <= (act == ACT_DYN_PAIR) ? dyn_rdata : sta_rdata;
          state <= S_CHA;
        end
        S_CHA: begin
          if (obj_a == NO_OBJECT) begin
            state <= S_CHB;
          end else if (!obj_in_range(obj_a, object_count)) begin
            rec_status <= ST_OBJECT;
            state      <= S_CHB;
          end else begin
            state <= S_WRA;
          end
        end
        S_WRA: begin
          rec_first <= 1'b1;
          state     <= S_CHB;
        end
        S_CHB: begin
          if (obj_b == obj_a || obj_b == NO_OBJECT) begin
            state <= S_DONE;
          end else if (!obj_in_range(obj_b, object_count)) begin
            rec_status <= ST_OBJECT;
            state      <= S_DONE;
          end else begin
            state <= S_WRB;
          end
        end
        S_WRB: begin
          rec_second <= 1'b1;
          state      <= S_DONE;
        end
        S_READ: begin
          rec_count <= cnt_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            count_value    <= rec_count;
            charged_first  <= rec_first;
            charged_second <= rec_second;
            status         <= rec_status;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No input transfer is taken as the counter clear begins after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> in_stall)
    else $error("input taken during counter clear");

  // A new result only appears after the sequencer has finished an action.
  assert property (@(posedge clk) disable iff (rst)
                   $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final step");

  // A counter value comes only from a read, which charges nothing.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && count_value != '0 |-> !charged_first && !charged_second)
    else $error("count value on a charging result");

  // Rejected records charge no counter.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && (status == ST_DISABLED || status == ST_VERTEX)
                   |-> !charged_first && !charged_second)
    else $error("charge on a rejected record");

endmodule

### bench/tb_object_contact_histogram.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_object_contact_histogram
// Self-checking bench for the object contact histogram. A scoreboard keeps
// its own copy of the counters, both vertex maps and the configuration. It
// predicts one result for every input transfer and compares each output
// transfer field by field. Stimulus starts with a directed pass over the
// special cases. Random phases under several configurations follow, with
// random idling on both channels and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_object_contact_histogram;
  import och_pkg::*;

  localparam int TB_OBJECTS  = 256;
  localparam int TB_OBJ_AW   = $clog2(TB_OBJECTS);
  localparam int TB_VERTICES = 4096;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic                first;
    logic                second;
    logic [STATUS_W-1:0] status;
  } contact_result_t;

  class contact_scoreboard;
    int unsigned           errors;
    logic [OBJ_W-1:0]      object_count;
    logic [CFG_DATA_W-1:0] dynamic_count;
    logic [CFG_DATA_W-1:0] static_count;
    logic [CNT_W-1:0]      counters [TB_OBJECTS];
    logic [OBJ_W-1:0]      dynamic_map [TB_VERTICES];
    logic [OBJ_W-1:0]      static_map [TB_VERTICES];
    contact_result_t       expected_q [$];

    function new();
      errors        = 0;
      object_count  = '0;
      dynamic_count = '0;
      static_count  = '0;
      foreach (counters[i]) counters[i] = '0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_OBJECT_COUNT:  object_count  = value[OBJ_W-1:0];
        CFG_DYNAMIC_COUNT: dynamic_count = value;
        CFG_STATIC_COUNT:  static_count  = value;
        default: ;
      endcase
    endfunction

    // Adds one to an object's counter. The no-object marker is skipped quietly,
    // while an object beyond the counted range is skipped and flags a fault.
    function bit bump(logic [OBJ_W-1:0] obj, int unsigned limit, inout bit fault);
      if (obj == NO_OBJECT) return 1'b0;
      if (obj >= limit) begin
        fault = 1'b1;
        return 1'b0;
      end
      counters[obj[TB_OBJ_AW-1:0]] = counters[obj[TB_OBJ_AW-1:0]] + 32'd1;
      return 1'b1;
    endfunction

    // Works out the result of one accepted input transfer and queues it.
    function void note_input(logic [ACT_W-1:0] act, logic [VTX_W-1:0] va,
                             logic [VTX_W-1:0] vb, logic [OBJ_W-1:0] oid);
      contact_result_t  res;
      int unsigned      n_obj, n_dyn, n_sta;
      logic [OBJ_W-1:0] oa, ob;
      bit               bad, fault;
      res   = '0;
      n_obj = 32'(object_count);
      n_dyn = 32'(dynamic_count);
      n_sta = 32'(static_count);
      if (n_obj > TB_OBJECTS) n_obj = TB_OBJECTS;
      if (n_dyn > TB_VERTICES) n_dyn = TB_VERTICES;
      if (n_sta > TB_VERTICES) n_sta = TB_VERTICES;
      case (act) inside
        ACT_DYN_PAIR, ACT_DYN_STATIC, ACT_ANALYTIC: begin
          if (n_obj == 0) begin
            res.status = ST_DISABLED;
          end else begin
            bad = (va >= n_dyn) || (act == ACT_DYN_PAIR && vb >= n_dyn) ||
                  (act == ACT_DYN_STATIC && vb >= n_sta);
            if (bad) begin
              res.status = ST_VERTEX;
            end else begin
              fault = 1'b0;
              oa = dynamic_map[va];
              if (act == ACT_DYN_PAIR) ob = dynamic_map[vb];
              else if (act == ACT_DYN_STATIC) ob = static_map[vb];
              else ob = NO_OBJECT;
              res.first = bump(oa, n_obj, fault);
              // A contact within one object is counted once.
              if (ob != oa) res.second = bump(ob, n_obj, fault);
              if (fault) res.status = ST_OBJECT;
            end
          end
        end
        ACT_LOAD_DYN:    dynamic_map[va] = oid;
        ACT_LOAD_STATIC: static_map[va] = oid;
        ACT_READ: begin
          if (oid < TB_OBJECTS) res.count = counters[oid[TB_OBJ_AW-1:0]];
          else res.status = ST_OBJECT;
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    // Compares one output transfer with the oldest expectation.
    function void check_result(contact_result_t got);
      contact_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: count_value %0d status %0d",
               got.count, got.status);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.count !== exp_r.count) begin
        $error("count_value: expected %0d, actual %0d", exp_r.count, got.count);
        errors++;
      end
      if (got.first !== exp_r.first) begin
        $error("charged_first: expected %0d, actual %0d", exp_r.first, got.first);
        errors++;
      end
      if (got.second !== exp_r.second) begin
        $error("charged_second: expected %0d, actual %0d", exp_r.second, got.second);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS      = 66;
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACT_W-1:0]      action;
  logic [VTX_W-1:0]      first_vertex;
  logic [VTX_W-1:0]      second_vertex;
  logic [OBJ_W-1:0]      object_id;
  logic                  out_valid;
  logic                  out_stall;
  logic [CNT_W-1:0]      count_value;
  logic                  charged_first;
  logic                  charged_second;
  logic [STATUS_W-1:0]   status;

  contact_scoreboard board;
  int unsigned       idle_cycles = 0;
  int unsigned       cur_obj = 0, cur_dyn = 0, cur_sta = 0;
  bit                dyn_loaded [TB_VERTICES];
  bit                sta_loaded [TB_VERTICES];
  int                dyn_addr_q [$];
  int                sta_addr_q [$];
  bit                hold_req = 1'b0;
  bit                sender_calm = 1'b0;
  bit                receiver_calm = 1'b0;

  object_contact_histogram dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .first_vertex   (first_vertex),
    .second_vertex  (second_vertex),
    .object_id      (object_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .count_value    (count_value),
    .charged_first  (charged_first),
    .charged_second (charged_second),
    .status         (status)
  );

  always #5 clk = ~clk;

  // Checks and predicts on every transfer; the watchdog counts quiet cycles.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result({count_value, charged_first, charged_second, status});
      if (in_valid && !in_stall)
        board.note_input(action, first_vertex, second_vertex, object_id);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: a random stall before every result, with calm stretches and a
  // long hold-off on request.
  initial begin : receiver
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_calm = !receiver_calm;
      n = receiver_calm ? 0 : $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        n = LONG_HOLD_CYCLES;
      end
      repeat (n) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Writes all three registers; the block is idle whenever this runs.
  task automatic write_config(int unsigned obj_n, int unsigned dyn_n, int unsigned sta_n);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OBJECT_COUNT;
    cfg_data  <= CFG_DATA_W'(obj_n);
    board.set_config(CFG_OBJECT_COUNT, CFG_DATA_W'(obj_n));
    @(negedge clk);
    cfg_index <= CFG_DYNAMIC_COUNT;
    cfg_data  <= CFG_DATA_W'(dyn_n);
    board.set_config(CFG_DYNAMIC_COUNT, CFG_DATA_W'(dyn_n));
    @(negedge clk);
    cfg_index <= CFG_STATIC_COUNT;
    cfg_data  <= CFG_DATA_W'(sta_n);
    board.set_config(CFG_STATIC_COUNT, CFG_DATA_W'(sta_n));
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_obj = obj_n;
    cur_dyn = dyn_n;
    cur_sta = sta_n;
  endtask

  // Offers one item after a random gap and holds it until the transfer.
  task automatic send_item(logic [ACT_W-1:0] act, logic [VTX_W-1:0] va,
                           logic [VTX_W-1:0] vb, logic [OBJ_W-1:0] oid);
    int gap;
    if (act == ACT_LOAD_DYN && !dyn_loaded[va]) begin
      dyn_loaded[va] = 1'b1;
      dyn_addr_q.push_back(int'(va));
    end
    if (act == ACT_LOAD_STATIC && !sta_loaded[va]) begin
      sta_loaded[va] = 1'b1;
      sta_addr_q.push_back(int'(va));
    end
    if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    first_vertex  <= va;
    second_vertex <= vb;
    object_id     <= oid;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Pauses the sender until every result is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly a vertex whose map entry is loaded and in range; otherwise one at
  // or past the configured count. Unloaded entries are never looked up.
  function automatic logic [VTX_W-1:0] pick_vertex(bit from_static);
    int unsigned n;
    int          idx;
    n = from_static ? cur_sta : cur_dyn;
    if (n > TB_VERTICES) n = TB_VERTICES;
    if ($urandom_range(0, 9) < 8 || n == TB_VERTICES) begin
      repeat (8) begin
        if (from_static) idx = sta_addr_q[$urandom_range(0, sta_addr_q.size() - 1)];
        else idx = dyn_addr_q[$urandom_range(0, dyn_addr_q.size() - 1)];
        if (idx < n) return VTX_W'(idx);
      end
    end
    if (n < TB_VERTICES) return VTX_W'($urandom_range(n, TB_VERTICES - 1));
    return VTX_W'(from_static ? sta_addr_q[0] : dyn_addr_q[0]);
  endfunction

  // Map values: often a few small objects, so that pairs often collide.
  function automatic logic [OBJ_W-1:0] pick_object();
    case ($urandom_range(0, 9))
      0, 1:    return NO_OBJECT;
      2, 3:    return OBJ_W'($urandom_range(0, 511));
      4, 5:    return OBJ_W'($urandom_range(0, 255));
      default: return OBJ_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_random_item();
    int               pick;
    logic [VTX_W-1:0] addr;
    logic [OBJ_W-1:0] oid;
    pick = $urandom_range(0, 99);
    addr = ($urandom_range(0, 3) == 0) ? VTX_W'($urandom_range(0, 4095))
                                       : VTX_W'($urandom_range(0, 63));
    if (pick < 12) begin
      send_item(ACT_LOAD_DYN, addr, VTX_W'($urandom), pick_object());
    end else if (pick < 22) begin
      send_item(ACT_LOAD_STATIC, addr, VTX_W'($urandom), pick_object());
    end else if (pick < 44) begin
      send_item(ACT_DYN_PAIR, pick_vertex(1'b0), pick_vertex(1'b0), OBJ_W'($urandom));
    end else if (pick < 64) begin
      send_item(ACT_DYN_STATIC, pick_vertex(1'b0), pick_vertex(1'b1), OBJ_W'($urandom));
    end else if (pick < 76) begin
      send_item(ACT_ANALYTIC, pick_vertex(1'b0), VTX_W'($urandom), OBJ_W'($urandom));
    end else if (pick < 94) begin
      case ($urandom_range(0, 6))
        0:       oid = OBJ_W'($urandom_range(0, 511));
        1, 2:    oid = OBJ_W'($urandom_range(0, 255));
        default: oid = OBJ_W'($urandom_range(0, 7));
      endcase
      send_item(ACT_READ, VTX_W'($urandom), VTX_W'($urandom), oid);
    end else begin
      send_item(pick[0] ? ACT_SPARE_6 : ACT_SPARE_7, VTX_W'($urandom),
                VTX_W'($urandom), OBJ_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_obj [8] = '{256, 1, 511, 0, 100, 37, 256, 200};
    int unsigned phase_dyn [8] = '{4096, 64, 8191, 100, 0, 3000, 128, 16};
    int unsigned phase_sta [8] = '{4096, 16, 8191, 100, 4096, 2, 128, 4095};
    board         = new();
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    action        = '0;
    first_vertex  = '0;
    second_vertex = '0;
    object_id     = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Registers at reset: recording is disabled, reads and loads still work.
    send_item(ACT_ANALYTIC, 12'd0, 12'd0, 9'd0);
    send_item(ACT_DYN_PAIR, 12'hFFF, 12'hFFF, NO_OBJECT);
    send_item(ACT_READ, 12'd0, 12'd0, 9'd0);
    send_item(ACT_READ, 12'hFFF, 12'hFFF, 9'h1FF);
    send_item(ACT_SPARE_6, 12'hFFF, 12'hFFF, 9'h1FF);
    send_item(ACT_SPARE_7, 12'd0, 12'd0, 9'd0);
    send_item(ACT_LOAD_DYN, 12'd0, 12'd0, 9'd0);
    send_item(ACT_LOAD_DYN, 12'd1, 12'd0, 9'd1);
    send_item(ACT_LOAD_DYN, 12'd2, 12'd0, NO_OBJECT);
    send_item(ACT_LOAD_DYN, 12'd3, 12'd0, 9'd300);
    send_item(ACT_LOAD_DYN, 12'hFFF, 12'd0, 9'd255);
    send_item(ACT_LOAD_STATIC, 12'd0, 12'd0, 9'd1);
    send_item(ACT_LOAD_STATIC, 12'hFFF, 12'd0, 9'd2);
    drain();

    // Four objects, five dynamic vertices, the full static map.
    write_config(4, 5, 4096);
    send_item(ACT_DYN_PAIR, 12'd0, 12'd1, 9'd0);
    send_item(ACT_DYN_PAIR, 12'd0, 12'd0, 9'd0);
    send_item(ACT_DYN_PAIR, 12'd0, 12'd2, 9'd0);
    send_item(ACT_DYN_PAIR, 12'd0, 12'd3, 9'd0);
    send_item(ACT_DYN_PAIR, 12'd1, 12'd5, 9'd0);
    send_item(ACT_DYN_STATIC, 12'd1, 12'hFFF, 9'd0);
    send_item(ACT_DYN_STATIC, 12'd6, 12'd0, 9'd0);
    send_item(ACT_ANALYTIC, 12'd2, 12'd0, 9'd0);
    send_item(ACT_ANALYTIC, 12'd3, 12'd0, 9'd0);
    send_item(ACT_READ, 12'd0, 12'd0, 9'd0);
    send_item(ACT_READ, 12'd0, 12'd0, 9'd1);
    send_item(ACT_READ, 12'd0, 12'd0, 9'd255);
    drain();

    // Random phases, each under its own configuration.
    for (int p = 0; p < 8; p++) begin
      write_config(phase_obj[p], phase_dyn[p], phase_sta[p]);
      if (p == 1 || p == 6) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end

    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
